// ===== hdl/kped_pkg.sv =====
// Package for the key press event detector.
// Holds flag positions, phase codes, register indexes and shared types.
// No dependencies.
package kped_pkg;

	localparam int NUM_KEYS_DEF = 4;
	// keys with a level input; keys at or above this read as released
	localparam int LEVEL_KEYS   = 4;
	localparam int FLAG_W       = 7;
	localparam int TIME_W       = 16;
	localparam int STAMP_W      = 32;
	localparam int FOUND_W      = 3;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 16;

	localparam int FLAG_HOLD_BIT   = 0;
	localparam int FLAG_DOWN_BIT   = 1;
	localparam int FLAG_UP_BIT     = 2;
	localparam int FLAG_SINGLE_BIT = 3;
	localparam int FLAG_DOUBLE_BIT = 4;
	localparam int FLAG_LONG_BIT   = 5;
	localparam int FLAG_REPEAT_BIT = 6;

	localparam logic [FLAG_W-1:0] FLAG_HOLD = 7'h01;

	localparam logic [TIME_W-1:0] SCAN_PERIOD_RST = 16'd20;
	localparam logic [TIME_W-1:0] LONG_PRESS_RST  = 16'd2000;
	localparam logic [TIME_W-1:0] DOUBLE_GAP_RST  = 16'd200;
	localparam logic [TIME_W-1:0] REPEAT_RST      = 16'd100;
	localparam logic [LEVEL_KEYS-1:0] ACTIVE_HIGH_RST = 4'd12;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCAN_PERIOD = 3'd0,
		REG_LONG_PRESS  = 3'd1,
		REG_DOUBLE_GAP  = 3'd2,
		REG_REPEAT      = 3'd3,
		REG_ACTIVE_HIGH = 3'd4
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_PRESSED = 3'd1,
		PH_WAIT    = 3'd2,
		PH_DOUBLE  = 3'd3,
		PH_LONG    = 3'd4
	} phase_t;

	// timing registers shared by all lanes
	typedef struct packed {
		logic [TIME_W-1:0] long_press;
		logic [TIME_W-1:0] double_gap;
		logic [TIME_W-1:0] repeat_ms;
	} lane_cfg_t;

	// per-item command broadcast to every lane
	typedef struct packed {
		logic              scan;
		logic [TIME_W-1:0] elapsed;
		logic              check;
		logic [FLAG_W-1:0] mask;
	} lane_cmd_t;

endpackage

// ===== hdl/kped_if.sv =====
// Handshake channel interfaces for the key press event detector.
// Input item, result item and configuration write channels; uses kped_pkg.
interface kped_in_if import kped_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               mode;
	logic [STAMP_W-1:0] now_ms;
	logic [LEVEL_KEYS-1:0] key_levels;
	logic [FLAG_W-1:0]  check_flags;

	modport source (output valid, mode, now_ms, key_levels, check_flags, input ready);
	modport sink (input valid, mode, now_ms, key_levels, check_flags, output ready);
endinterface

interface kped_out_if import kped_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic                  scan_done;
	logic [FOUND_W-1:0]    found_key;
	logic [LEVEL_KEYS-1:0] hold_mask;

	modport source (output valid, scan_done, found_key, hold_mask, input ready);
	modport sink (input valid, scan_done, found_key, hold_mask, output ready);
endinterface

interface kped_cfg_if import kped_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/key_press_event_detector.sv =====
// Key press event detector, top level.
// Result: registered at its item transfer and valid in the following cycle.
// Throughput: one item per cycle; all key lanes update together. While a result
// waits the input stalls; the next item enters in the cycle the result is taken.
// Reset: arst_n clears key state, last scan time and output valid, and loads
// the timing registers with their defaults. Depends on kped_pkg, kped_if, lanes, merge.
module key_press_event_detector import kped_pkg::*; #(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	kped_cfg_if.sink   cfg,
	kped_in_if.sink    item,
	kped_out_if.source result
);

	logic [TIME_W-1:0]     scan_period_q;
	lane_cfg_t             lane_cfg_q;
	logic [LEVEL_KEYS-1:0] active_high_q;
	logic [STAMP_W-1:0]    last_scan_q;

	logic                  out_valid_q, scan_done_q;
	logic [FOUND_W-1:0]    found_q;
	logic [LEVEL_KEYS-1:0] hold_q, hold_d;

	logic                  in_ready, acc, scan_ok;
	logic [STAMP_W-1:0]    diff;
	logic [TIME_W-1:0]     elapsed;
	lane_cmd_t             cmd;
	logic [NUM_KEYS-1:0]   match, clr, hold_next;
	logic [FOUND_W-1:0]    found_key;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_period_q         <= SCAN_PERIOD_RST;
			lane_cfg_q.long_press <= LONG_PRESS_RST;
			lane_cfg_q.double_gap <= DOUBLE_GAP_RST;
			lane_cfg_q.repeat_ms  <= REPEAT_RST;
			active_high_q         <= ACTIVE_HIGH_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SCAN_PERIOD: scan_period_q <= cfg.data;
				REG_LONG_PRESS:  lane_cfg_q.long_press <= cfg.data;
				REG_DOUBLE_GAP:  lane_cfg_q.double_gap <= cfg.data;
				REG_REPEAT:      lane_cfg_q.repeat_ms <= cfg.data;
				REG_ACTIVE_HIGH: active_high_q <= cfg.data[LEVEL_KEYS-1:0];
				default: ;
			endcase
		end
	end

	// item decode
	assign in_ready   = !out_valid_q || result.ready;
	assign item.ready = in_ready;
	assign acc        = item.valid && in_ready;
	assign diff       = item.now_ms - last_scan_q;
	assign elapsed    = diff[TIME_W-1:0];
	assign scan_ok    = (elapsed != '0) && (elapsed >= scan_period_q);

	always_comb begin
		cmd.scan    = acc && !item.mode && scan_ok;
		cmd.elapsed = elapsed;
		cmd.check   = acc && item.mode;
		cmd.mask    = item.check_flags;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) last_scan_q <= '0;
		else if (cmd.scan) last_scan_q <= item.now_ms;
	end

	// lanes
	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
		logic pressed;
		if (k < LEVEL_KEYS) begin : g_lvl
			assign pressed = (item.key_levels[k] == active_high_q[k]);
		end else begin : g_nolvl
			assign pressed = 1'b0;
		end
		kped_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.cfg       (lane_cfg_q),
			.cmd       (cmd),
			.pressed   (pressed),
			.clr       (clr[k]),
			.match     (match[k]),
			.hold_next (hold_next[k])
		);
	end

	kped_merge #(.NUM_KEYS(NUM_KEYS)) u_merge (
		.match     (match),
		.found_key (found_key),
		.clr       (clr)
	);

	always_comb begin
		hold_d = '0;
		for (int k = 0; k < NUM_KEYS && k < LEVEL_KEYS; k++) hold_d[k] = hold_next[k];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (in_ready) out_valid_q <= item.valid;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			scan_done_q <= cmd.scan;
			found_q     <= item.mode ? found_key : '0;
			hold_q      <= hold_d;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.scan_done = scan_done_q;
	assign result.found_key = found_q;
	assign result.hold_mask = hold_q;

	// checks
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> result.valid) else $error("transfer without result");

	a_found_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.found_key <= FOUND_W'(LEVEL_KEYS))
		else $error("found_key out of range");

	a_check_no_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.found_key != '0) |-> !result.scan_done)
		else $error("check result marked as scan");

	a_filter_keeps_time: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !item.mode && !scan_ok) |=> $stable(last_scan_q))
		else $error("filtered scan moved last scan time");

endmodule

// ===== hdl/kped_lane.sv =====
// One key lane: level, phase, countdown timer and event flags of a single key.
// Scans update it; clr clears masked flags on non-hold checks; uses kped_pkg.
module kped_lane import kped_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  lane_cfg_t cfg,
	input  lane_cmd_t cmd,
	input  logic      pressed,
	input  logic      clr,
	output logic      match,
	output logic      hold_next
);

	logic              level_q;
	phase_t            phase_q, phase_d;
	logic [TIME_W-1:0] timer_q, timer_d, timer_dec;
	logic [FLAG_W-1:0] flags_q, flags_d, f;

	assign match = |(flags_q & cmd.mask);

	always_comb begin
		timer_dec = (timer_q >= cmd.elapsed) ? timer_q - cmd.elapsed : '0;
		f = flags_q;
		f[FLAG_HOLD_BIT] = pressed;
		if (!level_q && pressed) f[FLAG_DOWN_BIT] = 1'b1;
		if (level_q && !pressed) f[FLAG_UP_BIT] = 1'b1;
		phase_d = phase_q;
		timer_d = timer_dec;
		case (phase_q)
			PH_IDLE: begin
				if (pressed) begin
					timer_d = cfg.long_press;
					phase_d = PH_PRESSED;
				end
			end
			PH_PRESSED: begin
				if (!pressed) begin
					timer_d = cfg.double_gap;
					phase_d = PH_WAIT;
				end else if (timer_dec == '0) begin
					timer_d = cfg.repeat_ms;
					f[FLAG_LONG_BIT] = 1'b1;
					phase_d = PH_LONG;
				end
			end
			PH_WAIT: begin
				if (pressed) begin
					f[FLAG_DOUBLE_BIT] = 1'b1;
					phase_d = PH_DOUBLE;
				end else if (timer_dec == '0) begin
					f[FLAG_SINGLE_BIT] = 1'b1;
					phase_d = PH_IDLE;
				end
			end
			PH_DOUBLE: begin
				if (!pressed) phase_d = PH_IDLE;
			end
			PH_LONG: begin
				if (!pressed) phase_d = PH_IDLE;
				else if (timer_dec == '0) begin
					timer_d = cfg.repeat_ms;
					f[FLAG_REPEAT_BIT] = 1'b1;
				end
			end
			default: ;
		endcase

		if (cmd.scan) flags_d = f;
		else if (cmd.check && clr && cmd.mask != FLAG_HOLD) flags_d = flags_q & ~cmd.mask;
		else flags_d = flags_q;
	end

	assign hold_next = flags_d[FLAG_HOLD_BIT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b0;
			phase_q <= PH_IDLE;
			timer_q <= '0;
			flags_q <= '0;
		end else begin
			flags_q <= flags_d;
			if (cmd.scan) begin
				level_q <= pressed;
				phase_q <= phase_d;
				timer_q <= timer_d;
			end
		end
	end

endmodule

// ===== hdl/kped_merge.sv =====
// Merge stage: picks the lowest reportable key whose flags match the mask.
// Also selects which lanes clear their flags; uses kped_pkg.
module kped_merge import kped_pkg::*; #(
	parameter int NUM_KEYS = NUM_KEYS_DEF
) (
	input  logic [NUM_KEYS-1:0] match,
	output logic [FOUND_W-1:0]  found_key,
	output logic [NUM_KEYS-1:0] clr
);

	logic blocked;

	// keys without a level input never stop the search
	always_comb begin
		blocked = 1'b0;
		found_key = '0;
		clr = '0;
		for (int k = 0; k < NUM_KEYS; k++) begin
			clr[k] = match[k] && !blocked;
			if (match[k] && !blocked && k < LEVEL_KEYS) begin
				found_key = FOUND_W'(k + 1);
				blocked = 1'b1;
			end
		end
	end

endmodule

// ===== verif/key_press_event_detector_test.sv =====
// Self-checking bench for key_press_event_detector: a directed walk through the
// press phases, then random key sequences under several register settings.
// Depends on kped_pkg, the kped channel interfaces and the detector RTL.
module key_press_event_detector_test;
	import kped_pkg::*;

	localparam logic MODE_SCAN  = 1'b0;
	localparam logic MODE_CHECK = 1'b1;
	localparam int SETTING_COUNT   = 8;
	localparam int ITEMS_PER_SET   = 215;
	localparam int HOLD_OFF_CYCLES = 80;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int PRINT_CAP       = 40;

	typedef struct packed {
		logic                  scan_done;
		logic [FOUND_W-1:0]    found_key;
		logic [LEVEL_KEYS-1:0] hold_mask;
	} key_result_t;

	// Tracks per-key press state and the results the detector owes us.
	class key_event_scoreboard;
		logic [TIME_W-1:0]     scan_period, long_press, double_gap, repeat_gap;
		logic [LEVEL_KEYS-1:0] active_high;
		logic [STAMP_W-1:0]    last_scan;
		logic                  level_now [NUM_KEYS_DEF];
		phase_t                phase [NUM_KEYS_DEF];
		logic [TIME_W-1:0]     timer [NUM_KEYS_DEF];
		logic [FLAG_W-1:0]     flags [NUM_KEYS_DEF];
		key_result_t           expected [$];
		int errors, items, scans_taken, scans_filtered, checks_hit;

		function new();
			scan_period = SCAN_PERIOD_RST;
			long_press  = LONG_PRESS_RST;
			double_gap  = DOUBLE_GAP_RST;
			repeat_gap  = REPEAT_RST;
			active_high = ACTIVE_HIGH_RST;
			last_scan   = '0;
			for (int k = 0; k < NUM_KEYS_DEF; k++) begin
				level_now[k] = 1'b0;
				phase[k]     = PH_IDLE;
				timer[k]     = '0;
				flags[k]     = '0;
			end
		endfunction

		function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_SCAN_PERIOD: scan_period = data[TIME_W-1:0];
				REG_LONG_PRESS:  long_press  = data[TIME_W-1:0];
				REG_DOUBLE_GAP:  double_gap  = data[TIME_W-1:0];
				REG_REPEAT:      repeat_gap  = data[TIME_W-1:0];
				REG_ACTIVE_HIGH: active_high = data[LEVEL_KEYS-1:0];
				default: ;
			endcase
		endfunction

		function void scan_key(int k, logic pressed);
			logic              prev;
			logic [FLAG_W-1:0] f;
			prev = level_now[k];
			f = flags[k];
			level_now[k] = pressed;
			f[FLAG_HOLD_BIT] = pressed;
			if (!prev && pressed)
				f[FLAG_DOWN_BIT] = 1'b1;
			if (prev && !pressed)
				f[FLAG_UP_BIT] = 1'b1;
			case (phase[k])
				PH_IDLE: if (pressed) begin
					timer[k] = long_press;
					phase[k] = PH_PRESSED;
				end
				PH_PRESSED: if (!pressed) begin
					timer[k] = double_gap;
					phase[k] = PH_WAIT;
				end else if (timer[k] == 0) begin
					timer[k] = repeat_gap;
					f[FLAG_LONG_BIT] = 1'b1;
					phase[k] = PH_LONG;
				end
				PH_WAIT: if (pressed) begin
					f[FLAG_DOUBLE_BIT] = 1'b1;
					phase[k] = PH_DOUBLE;
				end else if (timer[k] == 0) begin
					f[FLAG_SINGLE_BIT] = 1'b1;
					phase[k] = PH_IDLE;
				end
				PH_DOUBLE: if (!pressed)
					phase[k] = PH_IDLE;
				PH_LONG: if (!pressed) begin
					phase[k] = PH_IDLE;
				end else if (timer[k] == 0) begin
					timer[k] = repeat_gap;
					f[FLAG_REPEAT_BIT] = 1'b1;
				end
				default: ;
			endcase
			flags[k] = f;
		endfunction

		function void note_item(logic mode, logic [STAMP_W-1:0] now,
				logic [LEVEL_KEYS-1:0] levels, logic [FLAG_W-1:0] mask);
			key_result_t       r;
			logic [TIME_W-1:0] elapsed;
			r = '0;
			items++;
			if (mode == MODE_SCAN) begin
				elapsed = TIME_W'(now - last_scan);
				// zero elapsed is filtered even with a zero period
				if (elapsed != 0 && elapsed >= scan_period) begin
					last_scan = now;
					r.scan_done = 1'b1;
					scans_taken++;
					for (int k = 0; k < NUM_KEYS_DEF; k++)
						timer[k] = (timer[k] >= elapsed) ? timer[k] - elapsed : '0;
					for (int k = 0; k < NUM_KEYS_DEF; k++)
						scan_key(k, (k < LEVEL_KEYS) ? (levels[k] == active_high[k]) : 1'b0);
				end else begin
					scans_filtered++;
				end
			end else begin
				for (int k = 0; k < NUM_KEYS_DEF; k++) begin
					if ((flags[k] & mask) != 0) begin
						// a pure hold query leaves the flags alone
						if (mask != FLAG_HOLD)
							flags[k] &= ~mask;
						if (k < LEVEL_KEYS) begin
							r.found_key = FOUND_W'(k + 1);
							checks_hit++;
							break;
						end
					end
				end
			end
			for (int k = 0; k < LEVEL_KEYS && k < NUM_KEYS_DEF; k++)
				r.hold_mask[k] = flags[k][FLAG_HOLD_BIT];
			expected.push_back(r);
		endfunction

		function int pending();
			return expected.size();
		endfunction

		task report(string what);
			errors++;
			if (errors <= PRINT_CAP)
				$display("[%0t] mismatch: %s", $time, what);
		endtask

		task check_result(key_result_t got);
			key_result_t want;
			if (expected.size() == 0) begin
				report($sformatf("result %p with nothing outstanding", got));
				return;
			end
			want = expected.pop_front();
			if (got.scan_done !== want.scan_done)
				report($sformatf("scan_done %b, want %b", got.scan_done, want.scan_done));
			if (got.found_key !== want.found_key)
				report($sformatf("found_key %0d, want %0d", got.found_key, want.found_key));
			if (got.hold_mask !== want.hold_mask)
				report($sformatf("hold_mask %b, want %b", got.hold_mask, want.hold_mask));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	kped_cfg_if cfg_ch ();
	kped_in_if  item_ch ();
	kped_out_if result_ch ();

	key_press_event_detector u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.item   (item_ch),
		.result (result_ch)
	);

	key_event_scoreboard board = new();

	logic [STAMP_W-1:0]    stamp;
	logic [TIME_W-1:0]     period;
	logic [LEVEL_KEYS-1:0] pol_mask;
	logic                  send_steady, recv_steady, hold_req;
	int                    cycle_count, settings_used;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, board.pending());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// transfers are observed here so prediction and checking share one order
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready)
				board.note_item(item_ch.mode, item_ch.now_ms, item_ch.key_levels,
					item_ch.check_flags);
			if (result_ch.valid && result_ch.ready)
				board.check_result('{result_ch.scan_done, result_ch.found_key,
					result_ch.hold_mask});
		end
	end

	// result side: random stalls, plus an occasional long hold-off on request
	initial begin
		int stall;
		result_ch.ready = 1'b0;
		recv_steady = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				result_ch.ready = 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
			end
			if ($urandom_range(0, 39) == 0)
				recv_steady = !recv_steady;
			stall = recv_steady ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				result_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ch.ready = 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			@(negedge clk);
		end
	end

	function automatic logic [LEVEL_KEYS-1:0] levels_for(logic [LEVEL_KEYS-1:0] pressed);
		return ~(pressed ^ pol_mask);
	endfunction

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_item(logic mode, logic [STAMP_W-1:0] now,
			logic [LEVEL_KEYS-1:0] levels, logic [FLAG_W-1:0] mask);
		int gap;
		if ($urandom_range(0, 39) == 0)
			send_steady = !send_steady;
		gap = send_steady ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			item_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid       = 1'b1;
		item_ch.mode        = mode;
		item_ch.now_ms      = now;
		item_ch.key_levels  = levels;
		item_ch.check_flags = mask;
		do @(posedge clk); while (!item_ch.ready);
		@(negedge clk);
	endtask

	task automatic send_scan(logic [STAMP_W-1:0] now, logic [LEVEL_KEYS-1:0] levels);
		send_item(MODE_SCAN, now, levels, FLAG_W'($urandom));
	endtask

	task automatic send_check(logic [FLAG_W-1:0] mask);
		send_item(MODE_CHECK, $urandom, LEVEL_KEYS'($urandom), mask);
	endtask

	task automatic program_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data  = data;
		do @(posedge clk); while (!cfg_ch.ready);
		board.apply_reg(idx, data);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	task automatic wait_idle();
		while (board.pending() > 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic load_setting(int which);
		logic [TIME_W-1:0]     sp, lp, dg, rp;
		logic [LEVEL_KEYS-1:0] ah;
		logic [CFG_DATA_W-1:0] mask_word;
		case (which)
			0: begin
				sp = 16'd1; lp = '0; dg = '0; rp = '0; ah = '0;
			end
			// zero scan period: only a zero elapsed time is filtered
			1: begin
				sp = '0;
				lp = TIME_W'($urandom_range(0, 300));
				dg = TIME_W'($urandom_range(0, 150));
				rp = TIME_W'($urandom_range(0, 80));
				ah = LEVEL_KEYS'($urandom);
			end
			2: begin
				sp = '1; lp = '1; dg = '1; rp = '1; ah = '1;
			end
			3: begin
				sp = TIME_W'($urandom);
				lp = TIME_W'($urandom);
				dg = TIME_W'($urandom);
				rp = TIME_W'($urandom);
				ah = LEVEL_KEYS'($urandom);
			end
			default: begin
				sp = TIME_W'($urandom_range(1, 30));
				lp = TIME_W'($urandom_range(0, 400));
				dg = TIME_W'($urandom_range(0, 150));
				rp = TIME_W'($urandom_range(0, 80));
				ah = LEVEL_KEYS'($urandom);
			end
		endcase
		mask_word = CFG_DATA_W'($urandom);
		mask_word[LEVEL_KEYS-1:0] = ah;
		program_reg(REG_SCAN_PERIOD, sp);
		program_reg(REG_LONG_PRESS, lp);
		program_reg(REG_DOUBLE_GAP, dg);
		program_reg(REG_REPEAT, rp);
		program_reg(REG_ACTIVE_HIGH, mask_word);
		// indexes past the last register must be ignored
		for (int i = int'(REG_ACTIVE_HIGH) + 1; i < 2 ** CFG_IDX_W; i++)
			program_reg(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
		period   = sp;
		pol_mask = ah;
		settings_used++;
	endtask

	task automatic random_items(int count);
		int                    odds, r;
		logic [LEVEL_KEYS-1:0] pressed;
		logic [FLAG_W-1:0]     mask;
		case ($urandom_range(0, 2))
			0: odds = 2;
			1: odds = 6;
			default: odds = 24;
		endcase
		pressed = '0;
		repeat (count) begin
			if ($urandom_range(0, 99) < 35) begin
				r = $urandom_range(0, 9);
				if (r < 5)
					mask = FLAG_W'(1) << $urandom_range(0, FLAG_W - 1);
				else if (r < 6)
					mask = FLAG_HOLD;
				else if (r < 7)
					mask = '0;
				else
					mask = FLAG_W'($urandom);
				send_check(mask);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 70)
					stamp += period + ((period > 16'h4000) ? 0 : $urandom_range(0, period / 2 + 1));
				else if (r < 82)
					stamp += $urandom_range(0, period);
				else if (r < 87)
					stamp += 0;
				else if (r < 93)
					stamp += 32'h1_0000 + period;   // wraps the 16-bit elapsed time
				else
					stamp = $urandom;
				for (int k = 0; k < LEVEL_KEYS; k++)
					if ($urandom_range(1, odds) == 1)
						pressed[k] = !pressed[k];
				if ($urandom_range(0, 19) == 0)
					send_scan(stamp, LEVEL_KEYS'($urandom));
				else
					send_scan(stamp, levels_for(pressed));
			end
		end
		item_ch.valid = 1'b0;
	endtask

	initial begin
		arst_n              = 1'b0;
		item_ch.valid       = 1'b0;
		item_ch.mode        = MODE_SCAN;
		item_ch.now_ms      = '0;
		item_ch.key_levels  = '0;
		item_ch.check_flags = '0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.index        = REG_SCAN_PERIOD;
		cfg_ch.data         = '0;
		send_steady         = 1'b0;
		hold_req            = 1'b0;
		pol_mask            = ACTIVE_HIGH_RST;
		period              = SCAN_PERIOD_RST;
		stamp               = '0;
		cycle_count         = 0;
		settings_used       = 1;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed walk with the reset timing
		send_scan(32'd0, levels_for(4'hF));      // zero elapsed: filtered
		send_scan(32'd5, levels_for(4'hF));      // below the period: filtered
		send_check('0);
		send_scan(32'd20, levels_for(4'hF));     // every key goes down
		send_check(FLAG_HOLD);
		send_scan(32'd40, levels_for(4'hE));     // key 0 released
		send_scan(32'd100, levels_for(4'hF));    // key 0 second press
		send_scan(32'd2100, levels_for(4'hF));   // long press on the rest
		send_scan(32'd2200, levels_for(4'hF));   // first repeat
		for (int b = 0; b < FLAG_W; b++)
			send_check(FLAG_W'(1) << b);
		send_scan(32'd2220, levels_for(4'h0));
		send_scan(32'd2240, levels_for(4'h8));
		send_scan(32'd2260, levels_for(4'h0));
		send_scan(32'd2600, levels_for(4'h0));   // gap expired: single press
		send_check(FLAG_W'(1) << FLAG_SINGLE_BIT);
		send_scan('1, 4'hF);
		send_scan('0, 4'h0);                     // elapsed of one
		send_check('1);
		item_ch.valid = 1'b0;
		wait_idle();

		for (int s = 0; s < SETTING_COUNT; s++) begin
			load_setting(s);
			if (s == 4 || s == 6) begin
				// stall the result side while items keep coming
				hold_req    = 1'b1;
				send_steady = 1'b1;
			end
			random_items(ITEMS_PER_SET);
			wait_idle();
		end
		repeat (8) @(negedge clk);

		if (board.pending() != 0)
			board.report($sformatf("%0d results never arrived", board.pending()));
		$display("covered %0d items over %0d register settings", board.items, settings_used);
		$display("scans taken %0d, scans filtered %0d, checks that found a key %0d",
			board.scans_taken, board.scans_filtered, board.checks_hit);
		if (board.errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
